// ----- rtl/hbpp_pkg.sv -----
// ----------------------------------------------------------------------------
// hbpp_pkg
// Shared types and constants for the backdoor absolute pointer port.
// ----------------------------------------------------------------------------
`default_nettype none

package hbpp_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned CODE_W  = 16;
    localparam int unsigned FILL_W  = 3;
    localparam int unsigned Q_DEPTH = 4;

    localparam logic [WORD_W-1:0] MAGIC_WORD   = 32'h564d_5868;
    localparam logic [WORD_W-1:0] VERSION_WORD = 32'h3442_554a;
    localparam logic [WORD_W-1:0] SUB_ENABLE   = 32'h4541_4552;
    localparam logic [WORD_W-1:0] SUB_DISABLE  = 32'h0000_00f5;
    localparam logic [WORD_W-1:0] SUB_ABSOLUTE = 32'h5342_4152;
    localparam logic [WORD_W-1:0] SUB_RELATIVE = 32'h4c45_5252;

    localparam logic [CODE_W-1:0] CMD_VERSION = 16'd10;
    localparam logic [CODE_W-1:0] CMD_PACKET  = 16'd39;
    localparam logic [CODE_W-1:0] CMD_STATUS  = 16'd40;
    localparam logic [CODE_W-1:0] CMD_SUBCMD  = 16'd41;

    localparam logic [FILL_W-1:0] FILL_EMPTY = 3'd0;
    localparam logic [FILL_W-1:0] FILL_ONE   = 3'd1;
    localparam logic [FILL_W-1:0] FILL_FULL  = 3'd4;

    typedef enum logic [1:0] {
        MODE_BDOOR    = 2'd0,
        MODE_KBC_STAT = 2'd1,
        MODE_KBC_DATA = 2'd2,
        MODE_KBC_CMD  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        PEV_NONE = 2'd0,
        PEV_ABS  = 2'd1,
        PEV_OFF  = 2'd2
    } t_ptr_ev;

    typedef enum logic [1:0] {
        IRQ_NONE = 2'd0,
        IRQ_ON   = 2'd1,
        IRQ_OFF  = 2'd2
    } t_irq_ev;

    // controller -> datapath
    typedef struct packed {
        logic load;   // capture the input beat
        logic exec;   // decode, update state, register the result
    } t_ctl_cmd;

endpackage

`default_nettype wire

// ----- rtl/hbpp_ctrl.sv -----
// ----------------------------------------------------------------------------
// hbpp_ctrl
// Two-state sequencer: capture an access, then execute it and strobe done.
// ----------------------------------------------------------------------------
`default_nettype none

module hbpp_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    output logic                    o_done,
    output hbpp_pkg::t_ctl_cmd      o_cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;
    logic   r_done;

    always_comb begin
        o_cmd.load = (r_state == ST_IDLE) && start;
        o_cmd.exec = (r_state == ST_EXEC);
        n_state    = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != ST_IDLE);
            r_done  <= (r_state == ST_EXEC);
        end
    end

    assign busy   = r_busy;
    assign o_done = r_done;

endmodule

`default_nettype wire

// ----- rtl/hbpp_dp.sv -----
// ----------------------------------------------------------------------------
// hbpp_dp
// Datapath: input capture, command decode, reply queue, unlock latch.
// ----------------------------------------------------------------------------
`default_nettype none

module hbpp_dp (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire hbpp_pkg::t_ctl_cmd i_cmd,
    input  wire logic               i_feat_we,
    input  wire logic               i_feat_data,
    input  wire logic [1:0]         i_mode,
    input  wire logic [31:0]        i_access_magic,
    input  wire logic [15:0]        i_command_code,
    input  wire logic [31:0]        i_command_arg,
    input  wire logic               i_name_blocked,
    input  wire logic               i_sample_fresh,
    input  wire logic [7:0]         i_sample_buttons,
    input  wire logic [15:0]        i_sample_x,
    input  wire logic [15:0]        i_sample_y,
    input  wire logic [31:0]        i_sample_wheel,
    output logic [31:0]             o_reply_a,
    output logic [31:0]             o_reply_b,
    output logic [31:0]             o_reply_c,
    output logic [31:0]             o_reply_d,
    output logic [3:0]              o_written_mask,
    output logic                    o_taken_over,
    output logic                    o_unlocked_now,
    output logic [1:0]              o_pointer_event,
    output logic [1:0]              o_irq_event
);

    // captured access
    hbpp_pkg::t_mode r_mode;
    logic [31:0]     r_acc;
    logic [15:0]     r_code;
    logic [31:0]     r_arg;
    logic            r_blocked;
    logic            r_fresh;
    logic [7:0]      r_btn;
    logic [15:0]     r_x;
    logic [15:0]     r_y;
    logic [31:0]     r_wheel;

    // persistent state
    logic                          r_feat;
    logic [hbpp_pkg::FILL_W-1:0]   r_fill;
    logic [hbpp_pkg::FILL_W-1:0]   n_fill;
    logic                          r_unl;
    logic                          n_unl;
    logic [31:0]                   r_q [hbpp_pkg::Q_DEPTH];
    logic [31:0]                   n_q [hbpp_pkg::Q_DEPTH];

    // result
    logic [31:0]          r_a, r_b, r_c, r_d;
    logic [31:0]          n_a, n_b, n_c, n_d;
    logic [3:0]           r_mask, n_mask;
    logic                 r_taken, n_taken;
    hbpp_pkg::t_ptr_ev    r_pev, n_pev;
    hbpp_pkg::t_irq_ev    r_iev, n_iev;

    logic [1:0]  pop_idx;
    logic [31:0] pop_val;
    logic        refill;

    assign pop_idx = r_fill[1:0] - 2'd1;
    assign pop_val = (r_fill != hbpp_pkg::FILL_EMPTY) ? r_q[pop_idx] : '0;
    assign refill  = r_fresh && (r_fill != hbpp_pkg::FILL_ONE);

    always_comb begin
        n_a     = '0;
        n_b     = '0;
        n_c     = '0;
        n_d     = '0;
        n_mask  = '0;
        n_taken = 1'b0;
        n_pev   = hbpp_pkg::PEV_NONE;
        n_iev   = hbpp_pkg::IRQ_NONE;
        n_fill  = r_fill;
        n_unl   = r_unl;
        n_q     = r_q;
        if (r_feat) begin
            unique case (r_mode)
                hbpp_pkg::MODE_BDOOR: begin
                    n_mask = 4'b0001;
                    if (r_acc == hbpp_pkg::MAGIC_WORD) begin
                        n_a = hbpp_pkg::MAGIC_WORD;
                        unique case (r_code)
                            hbpp_pkg::CMD_VERSION: begin
                                if (!r_blocked) begin
                                    n_a    = '0;
                                    n_b    = hbpp_pkg::MAGIC_WORD;
                                    n_mask = 4'b0011;
                                end
                            end
                            hbpp_pkg::CMD_PACKET: begin
                                // full queue pops top first; anything partial is dropped
                                n_mask = 4'b1111;
                                n_fill = hbpp_pkg::FILL_EMPTY;
                                if (r_fill == hbpp_pkg::FILL_FULL) begin
                                    n_a = r_q[3];
                                    n_b = r_q[2];
                                    n_c = r_q[1];
                                    n_d = r_q[0];
                                end else begin
                                    n_a = '0;
                                end
                            end
                            hbpp_pkg::CMD_STATUS: begin
                                n_a = 32'(r_fill);
                                if (refill) begin
                                    n_q[0] = r_wheel;
                                    n_q[1] = 32'(r_y);
                                    n_q[2] = 32'(r_x);
                                    n_q[3] = 32'(r_btn);
                                    n_fill = hbpp_pkg::FILL_FULL;
                                    n_a    = 32'(hbpp_pkg::FILL_FULL);
                                end
                            end
                            hbpp_pkg::CMD_SUBCMD: begin
                                // enable's version word is pushed and popped at once
                                n_fill = hbpp_pkg::FILL_EMPTY;
                                if (r_arg == hbpp_pkg::SUB_ENABLE) begin
                                    n_iev  = hbpp_pkg::IRQ_OFF;
                                    n_a    = hbpp_pkg::VERSION_WORD;
                                    n_q[0] = hbpp_pkg::VERSION_WORD;
                                end else if (r_arg == hbpp_pkg::SUB_DISABLE) begin
                                    n_pev = hbpp_pkg::PEV_OFF;
                                end else if (r_arg == hbpp_pkg::SUB_ABSOLUTE) begin
                                    n_pev = hbpp_pkg::PEV_ABS;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                hbpp_pkg::MODE_KBC_STAT: begin
                    if (r_unl) begin
                        n_taken = 1'b1;
                        n_mask  = 4'b0001;
                        n_a     = 32'(r_fill);
                        if (refill) begin
                            n_q[0] = r_wheel;
                            n_q[1] = 32'(r_y);
                            n_q[2] = 32'(r_x);
                            n_q[3] = 32'(r_btn);
                            n_fill = hbpp_pkg::FILL_FULL;
                            n_a    = 32'(hbpp_pkg::FILL_FULL);
                        end
                    end
                end
                hbpp_pkg::MODE_KBC_DATA: begin
                    if (r_unl) begin
                        n_taken = 1'b1;
                        n_mask  = 4'b0001;
                        n_a     = pop_val;
                        if (r_fill != hbpp_pkg::FILL_EMPTY) begin
                            n_fill = r_fill - 3'd1;
                        end
                    end
                end
                hbpp_pkg::MODE_KBC_CMD: begin
                    if (!r_unl && (r_arg == hbpp_pkg::SUB_ENABLE)) begin
                        n_unl = 1'b1;
                        n_iev = hbpp_pkg::IRQ_ON;
                    end
                    n_taken = n_unl;
                    if (n_unl) begin
                        n_fill = hbpp_pkg::FILL_EMPTY;
                        if (r_arg == hbpp_pkg::SUB_ENABLE) begin
                            n_q[0] = hbpp_pkg::VERSION_WORD;
                            n_fill = hbpp_pkg::FILL_ONE;
                        end else if (r_arg == hbpp_pkg::SUB_DISABLE) begin
                            n_pev = hbpp_pkg::PEV_OFF;
                        end else if (r_arg == hbpp_pkg::SUB_ABSOLUTE) begin
                            n_pev = hbpp_pkg::PEV_ABS;
                        end
                    end
                    // disable relocks even from the locked state
                    if (r_arg == hbpp_pkg::SUB_DISABLE) begin
                        n_unl = 1'b0;
                        n_iev = hbpp_pkg::IRQ_OFF;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_feat <= 1'b0;
            r_fill <= hbpp_pkg::FILL_EMPTY;
            r_unl  <= 1'b0;
        end else begin
            if (i_feat_we) begin
                r_feat <= i_feat_data;
            end
            if (i_cmd.exec) begin
                r_fill <= n_fill;
                r_unl  <= n_unl;
            end
        end
    end

    // payload: captured beat, queue entries, result
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode    <= hbpp_pkg::t_mode'(i_mode);
            r_acc     <= i_access_magic;
            r_code    <= i_command_code;
            r_arg     <= i_command_arg;
            r_blocked <= i_name_blocked;
            r_fresh   <= i_sample_fresh;
            r_btn     <= i_sample_buttons;
            r_x       <= i_sample_x;
            r_y       <= i_sample_y;
            r_wheel   <= i_sample_wheel;
        end
        if (i_cmd.exec) begin
            r_q     <= n_q;
            r_a     <= n_a;
            r_b     <= n_b;
            r_c     <= n_c;
            r_d     <= n_d;
            r_mask  <= n_mask;
            r_taken <= n_taken;
            r_pev   <= n_pev;
            r_iev   <= n_iev;
        end
    end

    assign o_reply_a       = r_a;
    assign o_reply_b       = r_b;
    assign o_reply_c       = r_c;
    assign o_reply_d       = r_d;
    assign o_written_mask  = r_mask;
    assign o_taken_over    = r_taken;
    assign o_unlocked_now  = r_unl;
    assign o_pointer_event = r_pev;
    assign o_irq_event     = r_iev;

endmodule

`default_nettype wire

// ----- rtl/hypervisor_backdoor_pointer_port.sv -----
// ----------------------------------------------------------------------------
// hypervisor_backdoor_pointer_port
// Absolute pointer device behind a backdoor port and a controller side path.
// ----------------------------------------------------------------------------
// Usage:
//   Access channel: drive the access fields with start; the beat is taken on
//   a clock edge where start is high and busy is low. busy then rises for
//   one cycle while the access is decoded and the queue and unlock latch are
//   updated.
//   Result: o_done pulses for exactly one cycle, after the capture and execute
//   states, registered from the execute state, with all reply fields valid in
//   that cycle. The receiver cannot stall; the result is lost if not sampled
//   then. Results stay on the ports until the next access completes.
//   Back-to-back: a new access is not taken while one executes; busy drops in
//   the o_done cycle, so the next start may be taken on the edge that ends it.
//   The spacing is set by the capture-then-execute sequencer.
//   Config channel: i_cfg_valid/o_cfg_ready writes the feature-enable bit;
//   ready is high whenever the block is idle.
//   Reset (i_rst_n low, synchronous): feature off, queue empty, controller
//   path locked, no access in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module hypervisor_backdoor_pointer_port (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // access channel
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_mode,
    input  wire logic [31:0] i_access_magic,
    input  wire logic [15:0] i_command_code,
    input  wire logic [31:0] i_command_arg,
    input  wire logic        i_name_blocked,
    input  wire logic        i_sample_fresh,
    input  wire logic [7:0]  i_sample_buttons,
    input  wire logic [15:0] i_sample_x,
    input  wire logic [15:0] i_sample_y,
    input  wire logic [31:0] i_sample_wheel,
    // result
    output logic             o_done,
    output logic [31:0]      o_reply_a,
    output logic [31:0]      o_reply_b,
    output logic [31:0]      o_reply_c,
    output logic [31:0]      o_reply_d,
    output logic [3:0]       o_written_mask,
    output logic             o_taken_over,
    output logic             o_unlocked_now,
    output logic [1:0]       o_pointer_event,
    output logic [1:0]       o_irq_event,
    // config write channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_data
);

    hbpp_pkg::t_ctl_cmd cmd;
    logic               cfg_we;

    // config beats land only while nothing is in flight
    assign o_cfg_ready = !busy;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    hbpp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_done  (o_done),
        .o_cmd   (cmd)
    );

    hbpp_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_feat_we        (cfg_we),
        .i_feat_data      (i_cfg_data),
        .i_mode           (i_mode),
        .i_access_magic   (i_access_magic),
        .i_command_code   (i_command_code),
        .i_command_arg    (i_command_arg),
        .i_name_blocked   (i_name_blocked),
        .i_sample_fresh   (i_sample_fresh),
        .i_sample_buttons (i_sample_buttons),
        .i_sample_x       (i_sample_x),
        .i_sample_y       (i_sample_y),
        .i_sample_wheel   (i_sample_wheel),
        .o_reply_a        (o_reply_a),
        .o_reply_b        (o_reply_b),
        .o_reply_c        (o_reply_c),
        .o_reply_d        (o_reply_d),
        .o_written_mask   (o_written_mask),
        .o_taken_over     (o_taken_over),
        .o_unlocked_now   (o_unlocked_now),
        .o_pointer_event  (o_pointer_event),
        .o_irq_event      (o_irq_event)
    );

endmodule

`default_nettype wire

// ----- rtl/hbpp_chk.sv -----
// ----------------------------------------------------------------------------
// hbpp_chk
// Port-level checks on access sequencing and result strobes.
// ----------------------------------------------------------------------------
`default_nettype none

module hbpp_chk (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       o_done,
    input wire logic       o_cfg_ready,
    input wire logic [1:0] o_pointer_event,
    input wire logic [1:0] o_irq_event
);

    // an accepted beat yields a done once its execute state has passed
    a_done_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_done)
        else $error("done not seen two cycles after accepted beat");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted beat");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("done held longer than one cycle");

    a_done_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("done without an access in flight");

    a_events_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_pointer_event != 2'd3) && (o_irq_event != 2'd3) && o_cfg_ready)
        else $error("illegal event code or config blocked at done");

endmodule

bind hypervisor_backdoor_pointer_port hbpp_chk u_hbpp_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_done          (o_done),
    .o_cfg_ready     (o_cfg_ready),
    .o_pointer_event (o_pointer_event),
    .o_irq_event     (o_irq_event)
);

`default_nettype wire

// ----- test/hypervisor_backdoor_pointer_port_tb.sv -----
// ----------------------------------------------------------------------------
// hypervisor_backdoor_pointer_port_tb
// Self-checking bench for the backdoor absolute pointer port. Each accepted
// access beat is run through an in-bench model of the reply queue and the
// controller unlock latch. The predicted reply is queued and compared field
// by field with the next o_done beat. Stimulus starts with directed backdoor
// and controller sequences, then moves to mostly well-formed random traffic
// with random idle gaps, under both settings of the feature bit.
// ----------------------------------------------------------------------------
`default_nettype none

module hypervisor_backdoor_pointer_port_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // Cycles with no beat moving on any channel before the run is declared hung.
    localparam int unsigned IDLE_LIMIT   = 2000;
    // Restrict is a real backdoor command that this port leaves out.
    localparam logic [hbpp_pkg::CODE_W-1:0] CMD_RESTRICT = 16'd86;

    // One access beat, one field per port.
    typedef struct {
        hbpp_pkg::t_mode mode;
        logic [31:0]     magic;
        logic [15:0]     code;
        logic [31:0]     arg;
        logic            blocked;
        logic            fresh;
        logic [7:0]      buttons;
        logic [15:0]     x;
        logic [15:0]     y;
        logic [31:0]     wheel;
    } t_access;

    // One result beat.
    typedef struct {
        logic [31:0]       a;
        logic [31:0]       b;
        logic [31:0]       c;
        logic [31:0]       d;
        logic [3:0]        mask;
        logic              taken;
        logic              unlocked;
        hbpp_pkg::t_ptr_ev pev;
        hbpp_pkg::t_irq_ev iev;
    } t_reply;

    // ------------------------------------------------------------------------
    // DUT hookup; every input starts at a known value
    // ------------------------------------------------------------------------
    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        start            = 1'b0;
    logic        busy;
    logic [1:0]  i_mode           = hbpp_pkg::MODE_BDOOR;
    logic [31:0] i_access_magic   = '0;
    logic [15:0] i_command_code   = '0;
    logic [31:0] i_command_arg    = '0;
    logic        i_name_blocked   = 1'b0;
    logic        i_sample_fresh   = 1'b0;
    logic [7:0]  i_sample_buttons = '0;
    logic [15:0] i_sample_x       = '0;
    logic [15:0] i_sample_y       = '0;
    logic [31:0] i_sample_wheel   = '0;
    logic        o_done;
    logic [31:0] o_reply_a;
    logic [31:0] o_reply_b;
    logic [31:0] o_reply_c;
    logic [31:0] o_reply_d;
    logic [3:0]  o_written_mask;
    logic        o_taken_over;
    logic        o_unlocked_now;
    logic [1:0]  o_pointer_event;
    logic [1:0]  o_irq_event;
    logic        i_cfg_valid      = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_data       = 1'b0;

    hypervisor_backdoor_pointer_port u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_mode           (i_mode),
        .i_access_magic   (i_access_magic),
        .i_command_code   (i_command_code),
        .i_command_arg    (i_command_arg),
        .i_name_blocked   (i_name_blocked),
        .i_sample_fresh   (i_sample_fresh),
        .i_sample_buttons (i_sample_buttons),
        .i_sample_x       (i_sample_x),
        .i_sample_y       (i_sample_y),
        .i_sample_wheel   (i_sample_wheel),
        .o_done           (o_done),
        .o_reply_a        (o_reply_a),
        .o_reply_b        (o_reply_b),
        .o_reply_c        (o_reply_c),
        .o_reply_d        (o_reply_d),
        .o_written_mask   (o_written_mask),
        .o_taken_over     (o_taken_over),
        .o_unlocked_now   (o_unlocked_now),
        .o_pointer_event  (o_pointer_event),
        .o_irq_event      (o_irq_event),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data)
    );

    // 4 ns clock
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Shadow state of the device
    // ------------------------------------------------------------------------
    logic [31:0] ptr_queue [hbpp_pkg::Q_DEPTH];
    logic [2:0]  ptr_fill     = hbpp_pkg::FILL_EMPTY;
    logic        kbc_unlocked = 1'b0;
    logic        feature_on   = 1'b0;

    t_reply      reply_expected [$];
    int unsigned mismatches     = 0;
    int unsigned accesses_sent  = 0;
    int unsigned directed_sent  = 0;
    int unsigned feature_writes = 0;
    bit          no_idle        = 1'b0;   // burst stretch: back-to-back beats

    // Last-in pop; an empty queue reads as zero.
    function automatic logic [31:0] pop_word();
        if (ptr_fill == hbpp_pkg::FILL_EMPTY || ptr_fill > hbpp_pkg::FILL_FULL)
            return '0;
        ptr_fill = ptr_fill - 3'd1;
        return ptr_queue[ptr_fill[1:0]];
    endfunction

    // Status refill: only on a fresh sample, and never over a pending one-word
    // reply. Buttons land on top so they pop first.
    function automatic void refill_from(input t_access acc);
        if (!acc.fresh || ptr_fill == hbpp_pkg::FILL_ONE)
            return;
        ptr_queue[0] = acc.wheel;
        ptr_queue[1] = {16'h0, acc.y};
        ptr_queue[2] = {16'h0, acc.x};
        ptr_queue[3] = {24'h0, acc.buttons};
        ptr_fill     = hbpp_pkg::FILL_FULL;
    endfunction

    // Pointer subcommand: always flushes the queue; enable leaves the version
    // word as a one-word reply. Returns the pointer event it raises.
    function automatic hbpp_pkg::t_ptr_ev run_pointer_sub(input logic [31:0]       sub,
                                                          input hbpp_pkg::t_ptr_ev pev);
        ptr_fill = hbpp_pkg::FILL_EMPTY;
        if (sub == hbpp_pkg::SUB_ENABLE) begin
            ptr_queue[0] = hbpp_pkg::VERSION_WORD;
            ptr_fill     = hbpp_pkg::FILL_ONE;
        end else if (sub == hbpp_pkg::SUB_DISABLE) begin
            return hbpp_pkg::PEV_OFF;
        end else if (sub == hbpp_pkg::SUB_ABSOLUTE) begin
            return hbpp_pkg::PEV_ABS;
        end
        return pev;
    endfunction

    function automatic t_reply predict_reply(input t_access acc);
        t_reply r;
        r.a = '0; r.b = '0; r.c = '0; r.d = '0;
        r.mask = '0; r.taken = 1'b0; r.unlocked = 1'b0;
        r.pev = hbpp_pkg::PEV_NONE; r.iev = hbpp_pkg::IRQ_NONE;
        if (feature_on) begin
            case (acc.mode)
                hbpp_pkg::MODE_BDOOR: begin
                    r.mask = 4'b0001;
                    if (acc.magic == hbpp_pkg::MAGIC_WORD) begin
                        // unknown commands echo the magic back
                        r.a = hbpp_pkg::MAGIC_WORD;
                        if (acc.code == hbpp_pkg::CMD_VERSION) begin
                            if (!acc.blocked) begin
                                r.a    = '0;
                                r.b    = hbpp_pkg::MAGIC_WORD;
                                r.mask = 4'b0011;
                            end
                        end else if (acc.code == hbpp_pkg::CMD_PACKET) begin
                            r.mask = 4'b1111;
                            if (ptr_fill == hbpp_pkg::FILL_EMPTY ||
                                ptr_fill == hbpp_pkg::FILL_FULL) begin
                                r.a = pop_word();
                                r.b = pop_word();
                                r.c = pop_word();
                                r.d = pop_word();
                            end else begin
                                // partial packet: drop it
                                ptr_fill = hbpp_pkg::FILL_EMPTY;
                                r.a      = '0;
                            end
                        end else if (acc.code == hbpp_pkg::CMD_STATUS) begin
                            refill_from(acc);
                            r.a = {29'h0, ptr_fill};
                        end else if (acc.code == hbpp_pkg::CMD_SUBCMD) begin
                            if (acc.arg == hbpp_pkg::SUB_ENABLE)
                                r.iev = hbpp_pkg::IRQ_OFF;
                            r.pev = run_pointer_sub(acc.arg, r.pev);
                            if (ptr_fill == hbpp_pkg::FILL_ONE)
                                r.a = pop_word();
                        end
                    end
                end
                hbpp_pkg::MODE_KBC_STAT: begin
                    if (kbc_unlocked) begin
                        r.taken = 1'b1;
                        r.mask  = 4'b0001;
                        refill_from(acc);
                        r.a = {29'h0, ptr_fill};
                    end
                end
                hbpp_pkg::MODE_KBC_DATA: begin
                    if (kbc_unlocked) begin
                        r.taken = 1'b1;
                        r.mask  = 4'b0001;
                        r.a     = pop_word();
                    end
                end
                default: begin
                    if (!kbc_unlocked && acc.arg == hbpp_pkg::SUB_ENABLE) begin
                        kbc_unlocked = 1'b1;
                        r.iev        = hbpp_pkg::IRQ_ON;
                    end
                    r.taken = kbc_unlocked;
                    if (kbc_unlocked)
                        r.pev = run_pointer_sub(acc.arg, r.pev);
                    // disable relocks even when already locked
                    if (acc.arg == hbpp_pkg::SUB_DISABLE) begin
                        kbc_unlocked = 1'b0;
                        r.iev        = hbpp_pkg::IRQ_OFF;
                    end
                end
            endcase
        end
        r.unlocked = kbc_unlocked;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t ns: %s mismatch, expected %h, actual %h",
                     $time, name, exp_v, act_v);
            mismatches++;
        end
    endfunction

    // o_done is a one-cycle strobe that cannot be held off, so every edge
    // where it is high consumes the oldest prediction.
    always @(posedge i_clk) begin : result_check
        t_reply exp_r;
        if (i_rst_n && o_done === 1'b1) begin
            if (reply_expected.size() == 0) begin
                $display("%0t ns: result beat with no access outstanding, reply_a %h",
                         $time, o_reply_a);
                mismatches++;
            end else begin
                exp_r = reply_expected.pop_front();
                check_field("reply_a",       exp_r.a,             o_reply_a);
                check_field("reply_b",       exp_r.b,             o_reply_b);
                check_field("reply_c",       exp_r.c,             o_reply_c);
                check_field("reply_d",       exp_r.d,             o_reply_d);
                check_field("written_mask",  32'(exp_r.mask),     32'(o_written_mask));
                check_field("taken_over",    32'(exp_r.taken),    32'(o_taken_over));
                check_field("unlocked_now",  32'(exp_r.unlocked), 32'(o_unlocked_now));
                check_field("pointer_event", 32'(exp_r.pev),      32'(o_pointer_event));
                check_field("irq_event",     32'(exp_r.iev),      32'(o_irq_event));
            end
        end
    end

    // Watchdog: any beat on any channel resets the count.
    initial begin : watchdog
        int unsigned idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((start && !busy) || o_done === 1'b1 || (i_cfg_valid && o_cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t ns: no beat moved for %0d cycles", $time, IDLE_LIMIT);
        $display("[hypervisor_backdoor_pointer_port] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    // Mostly back-to-back or short gaps, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (no_idle || roll < 50)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Beat with given control fields and a random pointer sample.
    function automatic t_access make_access(input hbpp_pkg::t_mode m,
                                            input logic [31:0] magic,
                                            input logic [15:0] code, input logic [31:0] arg,
                                            input logic blocked, input logic fresh);
        t_access acc;
        acc.mode    = m;
        acc.magic   = magic;
        acc.code    = code;
        acc.arg     = arg;
        acc.blocked = blocked;
        acc.fresh   = fresh;
        acc.buttons = 8'($urandom_range(0, 255));
        acc.x       = 16'($urandom_range(0, 65535));
        acc.y       = 16'($urandom_range(0, 65535));
        acc.wheel   = $urandom;
        return acc;
    endfunction

    // Mostly legal traffic: right magic, known commands and subcommand words;
    // the rest is noise so every bit of every field toggles.
    function automatic t_access random_access();
        t_access         acc;
        int unsigned     roll;
        hbpp_pkg::t_mode m;
        logic [31:0]     magic;
        logic [15:0]     code;
        logic [31:0]     arg;
        roll = $urandom_range(0, 99);
        m = (roll < 55) ? hbpp_pkg::MODE_BDOOR : (roll < 70) ? hbpp_pkg::MODE_KBC_STAT :
            (roll < 85) ? hbpp_pkg::MODE_KBC_DATA : hbpp_pkg::MODE_KBC_CMD;
        roll = $urandom_range(0, 99);
        if (roll < 90)
            magic = hbpp_pkg::MAGIC_WORD;
        else if (roll < 95)
            magic = hbpp_pkg::MAGIC_WORD ^ (32'h1 << $urandom_range(0, 31));
        else
            magic = $urandom;
        roll = $urandom_range(0, 99);
        case ($urandom_range(0, 3))
            0: code = hbpp_pkg::CMD_VERSION;
            1: code = hbpp_pkg::CMD_PACKET;
            2: code = hbpp_pkg::CMD_STATUS;
            default: code = hbpp_pkg::CMD_SUBCMD;
        endcase
        if (roll >= 95)
            code = CMD_RESTRICT;
        else if (roll >= 85)
            code = 16'($urandom_range(0, 65535));
        roll = $urandom_range(0, 99);
        case ($urandom_range(0, 3))
            0: arg = hbpp_pkg::SUB_ENABLE;
            1: arg = hbpp_pkg::SUB_DISABLE;
            2: arg = hbpp_pkg::SUB_ABSOLUTE;
            default: arg = hbpp_pkg::SUB_RELATIVE;
        endcase
        if (roll >= 80)
            arg = $urandom;
        acc = make_access(m, magic, code, arg, $urandom_range(0, 99) < 30,
                          1'($urandom_range(0, 1)));
        return acc;
    endfunction

    // Present one access beat, hold it until taken, then idle for a while.
    // With no gap, start stays high straight into the next beat.
    task automatic send_access(input t_access acc);
        int unsigned gap;
        start            <= 1'b1;
        i_mode           <= acc.mode;
        i_access_magic   <= acc.magic;
        i_command_code   <= acc.code;
        i_command_arg    <= acc.arg;
        i_name_blocked   <= acc.blocked;
        i_sample_fresh   <= acc.fresh;
        i_sample_buttons <= acc.buttons;
        i_sample_x       <= acc.x;
        i_sample_y       <= acc.y;
        i_sample_wheel   <= acc.wheel;
        do @(posedge i_clk); while (busy);
        reply_expected = {reply_expected, predict_reply(acc)};
        accesses_sent++;
        gap = pick_gap();
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Let every outstanding access finish and its result be checked, then idle.
    task automatic drain_block();
        start <= 1'b0;
        while (reply_expected.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_feature(input logic value);
        drain_block();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        feature_on = value;
        feature_writes++;
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // With the feature off everything is swallowed, even an unlock attempt.
    task automatic test_feature_off();
        write_feature(1'b0);
        send_access(make_access(hbpp_pkg::MODE_BDOOR, hbpp_pkg::MAGIC_WORD,
                                hbpp_pkg::CMD_VERSION, '0, 1'b0, 1'b1));
        send_access(make_access(hbpp_pkg::MODE_KBC_CMD, '0, '0, hbpp_pkg::SUB_ENABLE,
                                1'b0, 1'b0));
        write_feature(1'b1);
    endtask

    task automatic test_backdoor_commands();
        t_access acc;
        // wrong magic, all-zero and one bit off
        send_access(make_access(hbpp_pkg::MODE_BDOOR, '0, hbpp_pkg::CMD_VERSION, '0,
                                1'b0, 1'b0));
        send_access(make_access(hbpp_pkg::MODE_BDOOR, hbpp_pkg::MAGIC_WORD ^ 32'h8000_0000,
                                hbpp_pkg::CMD_STATUS, '1, 1'b1, 1'b1));
        // version query open and hidden
        send_access(make_access(hbpp_pkg::MODE_BDOOR, hbpp_pkg::MAGIC_WORD,
                                hbpp_pkg::CMD_VERSION, '0, 1'b0, 1'b0));
        send_access(make_access(hbpp_pkg::MODE_BDOOR, hbpp_pkg::MAGIC_WORD,
                                hbpp_pkg::CMD_VERSION, '0, 1'b1, 1'b0));
        // restrict and an out-of-range code just echo the magic
        send_access(make_access(hbpp_pkg::MODE_BDOOR, hbpp_pkg::MAGIC_WORD,
                                CMD_RESTRICT, '0, 1'b0, 1'b0));
        send_access(make_access(hbpp_pkg::MODE_BDOOR, hbpp_pkg::MAGIC_WORD,
                                16'hffff, '1, 1'b0, 1'b0));
        // packet from an empty queue, then status with a stale sample
        send_access(make_access(hbpp_pkg::MODE_BDOOR, hbpp_pkg::MAGIC_WORD,
                                hbpp_pkg::CMD_PACKET, '0, 1'b0, 1'b0));
        send_access(make_access(hbpp_pkg::MODE_BDOOR, hbpp_pkg::MAGIC_WORD,
                                hbpp_pkg::CMD_STATUS, '0, 1'b0, 1'b0));
        // refill with an all-ones sample, fetch the full packet
        acc = make_access(hbpp_pkg::MODE_BDOOR, hbpp_pkg::MAGIC_WORD,
                          hbpp_pkg::CMD_STATUS, '0, 1'b0, 1'b1);
        acc.buttons = '1; acc.x = '1; acc.y = '1; acc.wheel = '1;
        send_access(acc);
        send_access(make_access(hbpp_pkg::MODE_BDOOR, hbpp_pkg::MAGIC_WORD,
                                hbpp_pkg::CMD_PACKET, '0, 1'b0, 1'b0));
        // refill with an all-zero sample, then let enable flush it
        acc = make_access(hbpp_pkg::MODE_BDOOR, hbpp_pkg::MAGIC_WORD,
                          hbpp_pkg::CMD_STATUS, '0, 1'b0, 1'b1);
        acc.buttons = '0; acc.x = '0; acc.y = '0; acc.wheel = '0;
        send_access(acc);
        send_access(make_access(hbpp_pkg::MODE_BDOOR, hbpp_pkg::MAGIC_WORD,
                                hbpp_pkg::CMD_SUBCMD, hbpp_pkg::SUB_ENABLE, 1'b0, 1'b0));
        send_access(make_access(hbpp_pkg::MODE_BDOOR, hbpp_pkg::MAGIC_WORD,
                                hbpp_pkg::CMD_SUBCMD, hbpp_pkg::SUB_ABSOLUTE, 1'b0, 1'b0));
        send_access(make_access(hbpp_pkg::MODE_BDOOR, hbpp_pkg::MAGIC_WORD,
                                hbpp_pkg::CMD_SUBCMD, hbpp_pkg::SUB_DISABLE, 1'b0, 1'b0));
        send_access(make_access(hbpp_pkg::MODE_BDOOR, hbpp_pkg::MAGIC_WORD,
                                hbpp_pkg::CMD_SUBCMD, hbpp_pkg::SUB_RELATIVE, 1'b0, 1'b0));
        send_access(make_access(hbpp_pkg::MODE_BDOOR, hbpp_pkg::MAGIC_WORD,
                                hbpp_pkg::CMD_SUBCMD, '1, 1'b0, 1'b0));
    endtask

    task automatic test_controller_path();
        // locked: reads ignored, disable still relocks and drops irqs
        send_access(make_access(hbpp_pkg::MODE_KBC_DATA, '0, '0, '0, 1'b0, 1'b1));
        send_access(make_access(hbpp_pkg::MODE_KBC_STAT, '0, '0, '0, 1'b0, 1'b1));
        send_access(make_access(hbpp_pkg::MODE_KBC_CMD, '0, '0, hbpp_pkg::SUB_DISABLE,
                                1'b0, 1'b0));
        // unlock; enable leaves the version word queued
        send_access(make_access(hbpp_pkg::MODE_KBC_CMD, '0, '0, hbpp_pkg::SUB_ENABLE,
                                1'b0, 1'b0));
        send_access(make_access(hbpp_pkg::MODE_KBC_DATA, '0, '0, '0, 1'b0, 1'b0));
        send_access(make_access(hbpp_pkg::MODE_KBC_DATA, '0, '0, '0, 1'b0, 1'b0));
        // refill through the controller, pop one, then fetch a partial packet
        send_access(make_access(hbpp_pkg::MODE_KBC_STAT, '0, '0, '0, 1'b0, 1'b1));
        send_access(make_access(hbpp_pkg::MODE_KBC_DATA, '0, '0, '0, 1'b0, 1'b0));
        send_access(make_access(hbpp_pkg::MODE_BDOOR, hbpp_pkg::MAGIC_WORD,
                                hbpp_pkg::CMD_PACKET, '0, 1'b0, 1'b0));
        // a pending one-word reply blocks the refill
        send_access(make_access(hbpp_pkg::MODE_KBC_CMD, '0, '0, hbpp_pkg::SUB_ENABLE,
                                1'b0, 1'b0));
        send_access(make_access(hbpp_pkg::MODE_KBC_STAT, '0, '0, '0, 1'b0, 1'b1));
        send_access(make_access(hbpp_pkg::MODE_KBC_CMD, '0, '0, hbpp_pkg::SUB_ABSOLUTE,
                                1'b0, 1'b0));
        send_access(make_access(hbpp_pkg::MODE_KBC_CMD, '0, '0, hbpp_pkg::SUB_DISABLE,
                                1'b0, 1'b0));
    endtask

    task automatic test_random_traffic(input int unsigned count);
        repeat (count) send_access(random_access());
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin : run_tests
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_feature_off();
        test_backdoor_commands();
        test_controller_path();
        directed_sent = accesses_sent;

        // rewrite the same value, then alternate phases
        write_feature(1'b1);
        test_random_traffic(200);
        write_feature(1'b0);
        test_random_traffic(20);
        write_feature(1'b1);
        test_random_traffic(170);
        no_idle = 1'b1;
        test_random_traffic(130);
        no_idle = 1'b0;

        drain_block();
        if (reply_expected.size() != 0) begin
            $display("%0t ns: %0d predicted replies never arrived",
                     $time, reply_expected.size());
            mismatches++;
        end
        $display("Ran %0d accesses (%0d directed) over backdoor and controller paths,",
                 accesses_sent, directed_sent);
        $display("with %0d feature-bit writes; %0d field mismatches seen.",
                 feature_writes, mismatches);
        if (mismatches == 0)
            $display("[hypervisor_backdoor_pointer_port] OK");
        else
            $display("[hypervisor_backdoor_pointer_port] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
